FILE: sv/drs_pkg.sv
// Shared types and constants for the delayed return scheduler.
// No dependencies; imported by drs_div and the top level.
package drs_pkg;

	localparam int HeapDepthDef   = 64;
	localparam int MaxHorizonsDef = 4;
	localparam int FracBits       = 29;
	localparam int DvdWidth       = 33 + FracBits;

	localparam logic [1:0] FUNC_QUERY = 2'd0;
	localparam logic [1:0] FUNC_EVAL  = 2'd1;
	localparam logic [1:0] FUNC_PEEK  = 2'd2;
	localparam logic [1:0] FUNC_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic [2:0] REG_COUNT  = 3'd0;
	localparam logic [2:0] REG_HOR0   = 3'd1;
	localparam logic [2:0] REG_HOR1   = 3'd2;
	localparam logic [2:0] REG_HOR2   = 3'd3;
	localparam logic [2:0] REG_HOR3   = 3'd4;
	localparam logic [2:0] REG_UNITS  = 3'd5;

	typedef struct packed {
		logic [63:0] due;
		logic [15:0] row;
		logic [31:0] bid;
		logic [31:0] ask;
	} entry_t;

	typedef struct packed {
		logic        neg;
		logic [32:0] mag;
		logic [32:0] den;
	} div_req_t;

endpackage

FILE: sv/drs_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module drs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/drs_div.sv
// Bit-serial fixed-point ratio unit: (mag << 29) / den, saturated to Q2.29.
// Depends on drs_pkg.
module drs_div import drs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  div_req_t    req,
	output logic        done,
	output logic [31:0] result
);

	localparam int CW = $clog2(DvdWidth);

	logic                busy_q;
	logic [CW-1:0]       cnt_q;
	logic [DvdWidth-1:0] dvd_q;
	logic [33:0]         rem_q;
	logic [32:0]         quo_q;
	logic                ovf_q;
	logic                neg_q;
	logic [32:0]         den_q;
	logic                done_q;
	logic [31:0]         res_q;

	logic [33:0] rem_n;
	logic        ge;
	logic [32:0] quo_n;
	logic        ovf_n;
	logic [31:0] fin;

	assign rem_n = {rem_q[32:0], dvd_q[DvdWidth-1]};
	assign ge    = rem_n >= {1'b0, den_q};
	assign quo_n = {quo_q[31:0], ge};
	assign ovf_n = ovf_q | quo_q[32];

	always_comb begin
		if (neg_q) begin
			fin = (ovf_n || quo_n > 33'h080000000) ? 32'h80000000 : 32'(33'd0 - quo_n);
		end else begin
			fin = (ovf_n || quo_n > 33'h07FFFFFFF) ? 32'h7FFFFFFF : quo_n[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				cnt_q  <= '0;
				busy_q <= (req.mag != '0) && (req.den != '0);
				done_q <= (req.mag == '0) || (req.den == '0);
			end else if (busy_q) begin
				cnt_q  <= cnt_q + 1'b1;
				busy_q <= (cnt_q != CW'(DvdWidth - 1));
				done_q <= (cnt_q == CW'(DvdWidth - 1));
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {req.mag, FracBits'(0)};
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
			neg_q <= req.neg;
			den_q <= req.den;
			if (req.mag == '0) begin
				res_q <= '0;
			end else if (req.den == '0) begin
				res_q <= req.neg ? 32'h80000000 : 32'h7FFFFFFF;
			end
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= ge ? rem_n - {1'b0, den_q} : rem_n;
			quo_q <= quo_n;
			ovf_q <= ovf_n;
			if (cnt_q == CW'(DvdWidth - 1)) begin
				res_q <= fin;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |=> !done || !busy_q)
		else $error("divider busy and done together");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> !done_q)
		else $error("divider done while still iterating");
	assert property (@(posedge clk) disable iff (!arst_n) (done_q && !start) |=> !done_q)
		else $error("divider done longer than one cycle");

endmodule

FILE: sv/delayed_return_scheduler.sv
// Delayed return scheduler top level: min-heap in RAM, push/pop sequencer.
// Depends on drs_pkg, drs_ram and drs_div.
//
// One word in, one word out. The block takes a word only when idle. A query
// pushes one entry per horizon and sifts each up the heap; an evaluate runs
// two ratios in the serial divider, then sifts down through the single heap
// RAM read port; peek, clear and failed queries skip the heap update.
// The heap RAM needs no clear.
module delayed_return_scheduler import drs_pkg::*; #(
	parameter int HEAP_DEPTH   = HeapDepthDef,
	parameter int MAX_HORIZONS = MaxHorizonsDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // now_time, best_bid, best_ask
	input  logic [1:0]   s_axis_tuser,  // func
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [151:0] m_axis_tdata,  // row, mid_return, side_return, earliest_time, status
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [29:0]  cfg_data
);

	localparam int IW = $clog2(HEAP_DEPTH);
	localparam int FW = $clog2(HEAP_DEPTH + 1);
	localparam int LW = IW + 2;
	localparam int EW = $bits(entry_t);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_MUL    = 5'd1;
	localparam logic [4:0] S_ADD    = 5'd2;
	localparam logic [4:0] S_UP_RD  = 5'd3;
	localparam logic [4:0] S_UP_CMP = 5'd4;
	localparam logic [4:0] S_EV_TOP = 5'd5;
	localparam logic [4:0] S_DIV1   = 5'd6;
	localparam logic [4:0] S_DIV2   = 5'd7;
	localparam logic [4:0] S_DN_LST = 5'd8;
	localparam logic [4:0] S_DN_CHK = 5'd9;
	localparam logic [4:0] S_DN_L   = 5'd10;
	localparam logic [4:0] S_DN_R   = 5'd11;
	localparam logic [4:0] S_DN_CMP = 5'd12;
	localparam logic [4:0] S_PEEK   = 5'd13;
	localparam logic [4:0] S_DONE   = 5'd14;
	localparam logic [4:0] S_EV_RD  = 5'd15;

	logic [4:0]  state_q;
	logic [2:0]  hcount_q;
	logic [16:0] horizon_q [4];
	logic [29:0] units_q;
	logic [FW-1:0] fill_q;
	logic [15:0] next_row_q;

	logic [2:0]  cnt_q;
	logic [2:0]  k_q;
	logic [63:0] now_q;
	logic [31:0] bid_q;
	logic [31:0] ask_q;
	logic [46:0] prod_q;
	entry_t      cur_q;
	entry_t      top_q;
	entry_t      ch_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] ch_idx_q;
	logic        mid_neg_q;

	logic [15:0] res_row_q;
	logic [31:0] res_mid_q;
	logic [31:0] res_side_q;
	logic [63:0] res_time_q;
	logic [1:0]  res_status_q;

	logic         out_valid_q;
	logic [151:0] out_data_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;
	entry_t        rd;

	logic        div_start;
	div_req_t    div_req;
	logic        div_done;
	logic [31:0] div_res;

	logic          s_fire;
	logic [2:0]    cnt_c;
	logic          full_c;
	logic [64:0]   sum_c;
	logic [IW-1:0] parent_c;
	logic [LW-1:0] l_c;
	logic [LW-1:0] r_c;
	logic [LW-1:0] fill_ext;
	logic [32:0]   num_pos;
	logic [32:0]   num_neg;
	logic          neg_c;

	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign rd            = entry_t'(ram_rdata);

	always_comb begin
		if (hcount_q == 3'd0) begin
			cnt_c = 3'd1;
		end else if (hcount_q > 3'(MAX_HORIZONS)) begin
			cnt_c = 3'(MAX_HORIZONS);
		end else begin
			cnt_c = hcount_q;
		end
	end

	assign full_c   = LW'(fill_q) + LW'(cnt_c) > LW'(HEAP_DEPTH);
	assign sum_c    = {1'b0, now_q} + {18'd0, prod_q};
	assign parent_c = IW'((i_q - 1'b1) >> 1);
	assign l_c      = LW'({i_q, 1'b1});
	assign r_c      = l_c + 1'b1;
	assign fill_ext = LW'(fill_q);
	assign num_pos  = {1'b0, bid_q} + {1'b0, ask_q};
	assign num_neg  = {1'b0, rd.bid} + {1'b0, rd.ask};
	assign neg_c    = num_pos < num_neg;

	always_comb begin
		div_start = 1'b0;
		div_req   = '0;
		if (state_q == S_EV_TOP) begin
			div_start   = 1'b1;
			div_req.neg = neg_c;
			div_req.mag = neg_c ? num_neg - num_pos : num_pos - num_neg;
			div_req.den = num_neg;
		end else if (state_q == S_DIV1 && div_done) begin
			div_start = 1'b1;
			if (mid_neg_q) begin
				div_req.neg = bid_q < top_q.bid;
				div_req.mag = div_req.neg ? 33'(top_q.bid - bid_q) : 33'(bid_q - top_q.bid);
				div_req.den = {1'b0, top_q.bid};
			end else begin
				div_req.neg = ask_q < top_q.ask;
				div_req.mag = div_req.neg ? 33'(top_q.ask - ask_q) : 33'(ask_q - top_q.ask);
				div_req.den = {1'b0, top_q.ask};
			end
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = i_q;
		ram_wdata = cur_q;
		ram_raddr = '0;
		unique case (state_q)
			S_UP_RD: begin
				ram_raddr = parent_c;
				if (i_q == '0) begin
					ram_we = 1'b1;
				end
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (cur_q.due < rd.due) begin
					ram_wdata = rd;
				end
			end
			S_DIV2: begin
				ram_raddr = IW'(fill_q - 1'b1);
			end
			S_DN_CHK: begin
				ram_raddr = IW'(l_c);
				if (l_c >= fill_ext) begin
					ram_we = 1'b1;
				end
			end
			S_DN_L: begin
				ram_raddr = IW'(r_c);
			end
			S_DN_CMP: begin
				ram_we = 1'b1;
				if (ch_q.due < cur_q.due) begin
					ram_wdata = ch_q;
				end
			end
			default: begin
			end
		endcase
	end

	drs_ram #(
		.WIDTH (EW),
		.DEPTH (HEAP_DEPTH)
	) u_heap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	drs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (div_req),
		.done   (div_done),
		.result (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			hcount_q     <= 3'd1;
			horizon_q[0] <= 17'd1;
			horizon_q[1] <= 17'd5;
			horizon_q[2] <= 17'd10;
			horizon_q[3] <= 17'd60;
			units_q      <= 30'd1000000;
			fill_q       <= '0;
			next_row_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_COUNT: hcount_q     <= cfg_data[2:0];
					REG_HOR0:  horizon_q[0] <= cfg_data[16:0];
					REG_HOR1:  horizon_q[1] <= cfg_data[16:0];
					REG_HOR2:  horizon_q[2] <= cfg_data[16:0];
					REG_HOR3:  horizon_q[3] <= cfg_data[16:0];
					REG_UNITS: units_q      <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						unique case (s_axis_tuser)
							FUNC_QUERY: state_q <= full_c ? S_DONE : S_MUL;
							FUNC_EVAL: state_q <= (fill_q == '0) ? S_DONE : S_EV_RD;
							FUNC_PEEK: state_q <= (fill_q == '0) ? S_DONE : S_PEEK;
							FUNC_CLEAR: begin
								fill_q     <= '0;
								next_row_q <= '0;
								state_q    <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_MUL:    state_q <= S_ADD;
				S_ADD: begin
					fill_q  <= fill_q + 1'b1;
					state_q <= S_UP_RD;
				end
				S_UP_RD: begin
					if (i_q == '0) begin
						if (k_q + 1'b1 == cnt_q) begin
							next_row_q <= next_row_q + 1'b1;
							state_q    <= S_DONE;
						end else begin
							state_q <= S_MUL;
						end
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (cur_q.due < rd.due) begin
						state_q <= S_UP_RD;
					end else if (k_q + 1'b1 == cnt_q) begin
						next_row_q <= next_row_q + 1'b1;
						state_q    <= S_DONE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_EV_RD:  state_q <= S_EV_TOP;
				S_EV_TOP: state_q <= S_DIV1;
				S_DIV1: begin
					if (div_done) begin
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_done) begin
						fill_q  <= fill_q - 1'b1;
						state_q <= (fill_q == FW'(1)) ? S_DONE : S_DN_LST;
					end
				end
				S_DN_LST: state_q <= S_DN_CHK;
				S_DN_CHK: state_q <= (l_c >= fill_ext) ? S_DONE : S_DN_L;
				S_DN_L:   state_q <= (r_c < fill_ext) ? S_DN_R : S_DN_CMP;
				S_DN_R:   state_q <= S_DN_CMP;
				S_DN_CMP: state_q <= (ch_q.due < cur_q.due) ? S_DN_CHK : S_DONE;
				S_PEEK:   state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				now_q      <= s_axis_tdata[63:0];
				bid_q      <= s_axis_tdata[95:64];
				ask_q      <= s_axis_tdata[127:96];
				cnt_q      <= cnt_c;
				k_q        <= '0;
				res_row_q  <= (s_axis_tuser == FUNC_QUERY) ? next_row_q : '0;
				res_mid_q  <= '0;
				res_side_q <= '0;
				res_time_q <= (s_axis_tuser == FUNC_PEEK && fill_q == '0) ? '1 : '0;
				if (s_axis_tuser == FUNC_QUERY && full_c) begin
					res_status_q <= ST_FULL;
				end else if ((s_axis_tuser == FUNC_EVAL || s_axis_tuser == FUNC_PEEK) &&
						fill_q == '0) begin
					res_status_q <= ST_EMPTY;
				end else begin
					res_status_q <= ST_OK;
				end
			end
			S_MUL: begin
				prod_q <= horizon_q[k_q[1:0]] * units_q;
			end
			S_ADD: begin
				cur_q.due <= sum_c[64] ? '1 : sum_c[63:0];
				cur_q.row <= next_row_q;
				cur_q.bid <= bid_q;
				cur_q.ask <= ask_q;
				i_q       <= IW'(fill_q);
			end
			S_UP_RD: begin
				if (i_q == '0) begin
					k_q <= k_q + 1'b1;
				end
			end
			S_UP_CMP: begin
				if (cur_q.due < rd.due) begin
					i_q <= parent_c;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			S_EV_TOP: begin
				top_q     <= rd;
				mid_neg_q <= neg_c;
				res_row_q <= rd.row;
			end
			S_DIV1: begin
				if (div_done) begin
					res_mid_q <= div_res;
				end
			end
			S_DIV2: begin
				if (div_done) begin
					res_side_q <= div_res;
				end
			end
			S_DN_LST: begin
				cur_q <= rd;
				i_q   <= '0;
			end
			S_DN_L: begin
				ch_q     <= rd;
				ch_idx_q <= IW'(l_c);
			end
			S_DN_R: begin
				if (rd.due < ch_q.due) begin
					ch_q     <= rd;
					ch_idx_q <= IW'(r_c);
				end
			end
			S_DN_CMP: begin
				if (ch_q.due < cur_q.due) begin
					i_q <= ch_idx_q;
				end
			end
			S_PEEK: begin
				res_time_q <= rd.due;
			end
			S_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					out_data_q <= {6'd0, res_status_q, res_time_q, res_side_q,
						res_mid_q, res_row_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assert property (@(posedge clk) disable iff (!arst_n) LW'(fill_q) <= LW'(HEAP_DEPTH))
		else $error("heap fill beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && s_axis_tuser == FUNC_CLEAR) |=> (fill_q == '0 && next_row_q == '0))
		else $error("clear left heap state");
	assert property (@(posedge clk) disable iff (!arst_n) s_fire |=> !s_axis_tready)
		else $error("new word taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DN_CHK) |-> (fill_q != '0))
		else $error("sift-down on empty heap");

endmodule
